@@ rtl/kmq_pkg.sv @@
// Package for the keyed multi-queue FIFO: sizes, operation and status codes.
// Used by every module of the block; no dependencies.
package kmq_pkg;
   localparam int NumKeys   = 256;
   localparam int PoolNodes = 1024;
   localparam int ValueBits = 32;
   localparam int KeyBits   = $clog2(NumKeys);
   localparam int NodeBits  = $clog2(PoolNodes);
   localparam int CntBits   = NodeBits + 1;
   localparam int CfgBits   = 9;

   localparam logic [1:0] KIND_PUSH = 2'd0;
   localparam logic [1:0] KIND_READ = 2'd1;
   localparam logic [1:0] KIND_POP  = 2'd2;
   localparam logic [1:0] KIND_NOP  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [1:0]           kind;
      logic                 reject;
      logic [KeyBits-1:0]   key;
      logic [ValueBits-1:0] value;
   } cmd_type;
endpackage

@@ rtl/kmq_front.sv @@
// Front end: takes request beats, checks the key against the key count,
// and holds one classified command for the back end. Depends on kmq_pkg.
module kmq_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_kind,
   input  logic [7:0]             req_key,
   input  logic [31:0]            req_value,
   input  logic [8:0]             key_count,
   output logic                   cmd_valid,
   output kmq_pkg::cmd_type       cmd,
   input  logic                   cmd_take
);
   import kmq_pkg::*;
   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   assign req_stall = valid_ff && !cmd_take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = accept || (valid_ff && !cmd_take);
      cmd_in   = cmd_ff;
      if (accept) begin
         cmd_in.kind   = req_kind;
         cmd_in.key    = req_key;
         cmd_in.value  = req_value;
         cmd_in.reject = ({1'b0, req_key} >= key_count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;
endmodule

@@ rtl/kmq_back.sv @@
// Back end: queue table, node pool and free list; each command runs as table read,
// node read, then write and respond, held while the response stalls. Depends on kmq_pkg.
module kmq_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  kmq_pkg::cmd_type  cmd,
   output logic              cmd_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [31:0]       rsp_front_value
);
   import kmq_pkg::*;
   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_EXEC = 1'b1;

   logic [NodeBits-1:0]  head_mem [NumKeys];
   logic [NodeBits-1:0]  tail_mem [NumKeys];
   logic [ValueBits-1:0] pay_mem  [PoolNodes];
   logic [NodeBits-1:0]  link_mem [PoolNodes];
   logic [NumKeys-1:0]   nonempty_ff;

   logic [0:0]           state_ff;
   cmd_type              op_ff;
   logic [NodeBits-1:0]  head_rd_ff, tail_rd_ff, flink_rd_ff, hlink_rd_ff;
   logic [ValueBits-1:0] pay_rd_ff;
   logic [NodeBits-1:0]  free_head_ff;
   logic [CntBits-1:0]   free_len_ff, fresh_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           status_ff;
   logic [ValueBits-1:0] front_ff;

   logic out_free, start, ne, have_free, have_fresh, commit;
   logic [NodeBits-1:0] new_node;
   logic [1:0] sub_ff;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign start      = state_ff == S_IDLE && cmd_valid;
   assign cmd_take   = start;
   assign ne         = nonempty_ff[op_ff.key];
   assign have_free  = free_len_ff != '0;
   assign have_fresh = fresh_ff < CntBits'(PoolNodes);
   assign new_node   = have_free ? free_head_ff : fresh_ff[NodeBits-1:0];
   assign commit     = state_ff == S_EXEC && sub_ff == 2'd1 && out_free;

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff       <= cmd;
         head_rd_ff  <= head_mem[cmd.key];
         tail_rd_ff  <= tail_mem[cmd.key];
         flink_rd_ff <= link_mem[free_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (commit && op_ff.kind == KIND_PUSH &&
          !op_ff.reject && (have_free || have_fresh)) begin
         pay_mem[new_node]  <= op_ff.value;
         tail_mem[op_ff.key] <= new_node;
         if (!ne) head_mem[op_ff.key] <= new_node;
      end else if (commit && op_ff.kind == KIND_POP &&
                   !op_ff.reject && ne && head_rd_ff != tail_rd_ff) begin
         head_mem[op_ff.key] <= hlink_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && !op_ff.reject && op_ff.kind == KIND_PUSH &&
          ne && (have_free || have_fresh)) begin
         link_mem[tail_rd_ff] <= new_node;
      end else if (commit && !op_ff.reject &&
                   op_ff.kind == KIND_POP && ne) begin
         link_mem[head_rd_ff] <= free_head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sub_ff       <= 2'd0;
         nonempty_ff  <= '0;
         free_head_ff <= '0;
         free_len_ff  <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_EXEC;
                  sub_ff   <= 2'd0;
               end
            end
            S_EXEC: begin
               if (sub_ff == 2'd0) begin
                  pay_rd_ff   <= pay_mem[head_rd_ff];
                  hlink_rd_ff <= link_mem[head_rd_ff];
                  sub_ff      <= 2'd1;
               end else if (out_free) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b1;
                  front_ff     <= '0;
                  status_ff    <= ST_OK;
                  if (op_ff.kind == KIND_NOP) begin
                     status_ff <= ST_OK;
                  end else if (op_ff.reject) begin
                     status_ff <= ST_RANGE;
                  end else if (op_ff.kind == KIND_PUSH) begin
                     if (have_free) begin
                        free_head_ff <= flink_rd_ff;
                        free_len_ff  <= free_len_ff - 1'b1;
                        nonempty_ff[op_ff.key] <= 1'b1;
                     end else if (have_fresh) begin
                        fresh_ff <= fresh_ff + 1'b1;
                        nonempty_ff[op_ff.key] <= 1'b1;
                     end else begin
                        status_ff <= ST_FULL;
                     end
                  end else if (!ne) begin
                     status_ff <= ST_EMPTY;
                  end else begin
                     front_ff <= pay_rd_ff;
                     if (op_ff.kind == KIND_POP) begin
                        if (head_rd_ff == tail_rd_ff) nonempty_ff[op_ff.key] <= 1'b0;
                        free_head_ff <= head_rd_ff;
                        free_len_ff  <= free_len_ff + 1'b1;
                     end
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_front_value = front_ff;

   a_pool: assert property (@(posedge clock) disable iff (reset)
      free_len_ff <= fresh_ff) else $error("free list longer than issued nodes");
   a_fresh: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= CntBits'(PoolNodes)) else $error("fresh count overflow");
   a_take: assert property (@(posedge clock) disable iff (reset)
      cmd_take |=> state_ff == S_EXEC) else $error("command lost");
endmodule

@@ rtl/keyed_multi_queue_fifo_unit.sv @@
// Keyed multi-queue FIFO: 256 linked-list queues sharing a 1024-node pool.
// A request is held in a one-entry front register and then runs through the
// back end (table read, node read, update and respond); the back end finishes
// one request before it takes the next, while the front register can hold one
// more. A stalled response holds the back end in its update step. The csr port
// sets the key count (reset 256). Depends on kmq_pkg, kmq_front, kmq_back.
module keyed_multi_queue_fifo_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_key,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_front_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data
);
   import kmq_pkg::*;
   logic [CfgBits-1:0] key_count_ff;
   logic    cmd_valid, cmd_take;
   cmd_type cmd;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) key_count_ff <= CfgBits'(256);
      else if (csr_valid) key_count_ff <= csr_data;
   end

   kmq_front u_front (.clock, .reset, .req_valid, .req_stall, .req_kind, .req_key,
      .req_value, .key_count(key_count_ff), .cmd_valid, .cmd, .cmd_take);
   kmq_back u_back (.clock, .reset, .cmd_valid, .cmd, .cmd_take, .rsp_valid,
      .rsp_stall, .rsp_status, .rsp_front_value);
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for keyed_multi_queue_fifo_unit: directed table, key-count and
// pool-overflow checks, then random push/read/pop/nop traffic checked against a
// behavioral model of the queue pool. Depends on kmq_pkg and the RTL of the block only.
module tb;
   import kmq_pkg::*;

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  key;
      logic [31:0] value;
      logic        typed;
      logic [1:0]  status;
      logic [31:0] front;
   } row_type;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] front;
   } beat_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_kind = 0;
   logic [7:0]  req_key = 0;
   logic [31:0] req_value = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_front_value;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [8:0]  csr_data = 0;

   keyed_multi_queue_fifo_unit i_dut (.*);

   always #4 clock = ~clock;

   // model of the queue table
   logic [8:0]  key_limit;
   int unsigned head_node [NumKeys];
   int unsigned tail_node [NumKeys];
   bit          busy_key [NumKeys];
   logic [31:0] payload [PoolNodes];
   int unsigned link [PoolNodes];
   int unsigned free_head, free_len, fresh_used;

   beat_type expected_beats[$];
   row_type  table_rows[$];
   int    send_idle_pct, recv_idle_pct;
   bit    hold_rsp;
   int    errors;
   longint cycles;

   function automatic beat_type queue_op(logic [1:0] kind, logic [7:0] key,
                                         logic [31:0] value);
      beat_type r;
      int unsigned lim, node, h;
      r.status = ST_OK;
      r.front = 0;
      lim = (key_limit < NumKeys) ? key_limit : NumKeys;
      if (kind == KIND_NOP) return r;
      if (key >= lim) begin
         r.status = ST_RANGE;
         return r;
      end
      if (kind == KIND_PUSH) begin
         if (free_len > 0) begin
            node = free_head;
            free_head = link[node];
            free_len--;
         end else if (fresh_used < PoolNodes) begin
            node = fresh_used;
            fresh_used++;
         end else begin
            r.status = ST_FULL;
            return r;
         end
         payload[node] = value;
         link[node] = 0;
         if (busy_key[key]) begin
            link[tail_node[key]] = node;
            tail_node[key] = node;
         end else begin
            head_node[key] = node;
            tail_node[key] = node;
            busy_key[key] = 1;
         end
      end else if (!busy_key[key]) begin
         r.status = ST_EMPTY;
      end else begin
         h = head_node[key];
         r.front = payload[h];
         if (kind == KIND_POP) begin
            if (h == tail_node[key]) busy_key[key] = 0;
            else head_node[key] = link[h];
            link[h] = free_head;
            free_head = h;
            free_len++;
         end
      end
      return r;
   endfunction

   task automatic send_beat(logic [1:0] kind, logic [7:0] key, logic [31:0] value,
                            bit typed = 0, logic [1:0] st = 0, logic [31:0] fv = 0);
      beat_type p;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_key <= key;
      req_value <= value;
      p = queue_op(kind, key, value);
      if (typed && (p.status !== st || p.front !== fv)) begin
         $error("table row disagrees with model: kind %0d key %0d", kind, key);
         errors++;
      end
      if (typed) begin
         p.status = st;
         p.front = fv;
      end
      expected_beats.push_back(p);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (expected_beats.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_key_count(logic [8:0] v);
      csr_valid <= 1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      key_limit = v;
   endtask

   function automatic row_type mk(logic [1:0] k, logic [7:0] key, logic [31:0] v,
                                  bit typed = 0, logic [1:0] s = 0, logic [31:0] f = 0);
      row_type r;
      r.kind = k; r.key = key; r.value = v; r.typed = typed; r.status = s; r.front = f;
      return r;
   endfunction

   task automatic random_phase(int n, int key_span);
      logic [1:0] k;
      int unsigned roll;
      repeat (n) begin
         roll = $urandom_range(99);
         k = (roll < 50) ? KIND_PUSH : (roll < 70) ? KIND_READ :
             (roll < 97) ? KIND_POP : KIND_NOP;
         send_beat(k, (roll % 10 == 0) ? 8'($urandom) : 8'($urandom_range(key_span)),
                   $urandom);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: status %0d front_value %h", rsp_status,
                   rsp_front_value);
            errors++;
         end else begin
            e = expected_beats.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_front_value !== e.front) begin
               $error("front_value: expected %h, actual %h", e.front, rsp_front_value);
               errors++;
            end
         end
      end
   end

   // receiver stall
   always @(posedge clock)
      rsp_stall <= hold_rsp || (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);

   always @(posedge clock) begin
      cycles++;
      if (cycles > 2000000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      errors = 0;
      cycles = 0;
      hold_rsp = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      key_limit = 256;
      free_head = 0; free_len = 0; fresh_used = 0;
      foreach (busy_key[i]) busy_key[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      table_rows.push_back(mk(KIND_READ, 8'd0, 0, 1, ST_EMPTY, 0));
      table_rows.push_back(mk(KIND_POP, 8'd255, 0, 1, ST_EMPTY, 0));
      table_rows.push_back(mk(KIND_PUSH, 8'd0, 32'hFFFF_FFFF, 1, ST_OK, 0));
      table_rows.push_back(mk(KIND_PUSH, 8'd0, 32'h0, 1, ST_OK, 0));
      table_rows.push_back(mk(KIND_PUSH, 8'd255, 32'hA5A5_5A5A, 1, ST_OK, 0));
      table_rows.push_back(mk(KIND_READ, 8'd0, 32'h1234, 1, ST_OK, 32'hFFFF_FFFF));
      table_rows.push_back(mk(KIND_POP, 8'd0, 0, 1, ST_OK, 32'hFFFF_FFFF));
      table_rows.push_back(mk(KIND_POP, 8'd0, 0, 1, ST_OK, 0));
      table_rows.push_back(mk(KIND_POP, 8'd0, 0, 1, ST_EMPTY, 0));
      table_rows.push_back(mk(KIND_NOP, 8'd7, 32'hDEAD_BEEF, 1, ST_OK, 0));
      table_rows.push_back(mk(KIND_PUSH, 8'd0, 32'h5555_AAAA));
      table_rows.push_back(mk(KIND_PUSH, 8'd0, 32'hAAAA_5555));
      table_rows.push_back(mk(KIND_READ, 8'd255, 0, 1, ST_OK, 32'hA5A5_5A5A));
      table_rows.push_back(mk(KIND_POP, 8'd255, 0));
      table_rows.push_back(mk(KIND_POP, 8'd0, 0));
      table_rows.push_back(mk(KIND_PUSH, 8'd1, 32'h0F0F_F0F0));
      foreach (table_rows[i])
         send_beat(table_rows[i].kind, table_rows[i].key, table_rows[i].value,
                   table_rows[i].typed, table_rows[i].status, table_rows[i].front);
      drain();

      write_key_count(9'd1);
      send_beat(KIND_PUSH, 8'd1, 32'h1, 1, ST_RANGE, 0);
      send_beat(KIND_READ, 8'd128, 0, 1, ST_RANGE, 0);
      send_beat(KIND_POP, 8'd0, 0);
      drain();
      write_key_count(9'd0);
      send_beat(KIND_PUSH, 8'd0, 32'h1, 1, ST_RANGE, 0);
      send_beat(KIND_NOP, 8'd0, 0, 1, ST_OK, 0);
      drain();
      write_key_count(9'h1FF);

      // fill the pool to overflow while the receiver holds off
      fork
         begin
            hold_rsp = 1;
            repeat (600) @(posedge clock);
            hold_rsp = 0;
         end
         repeat (1030) send_beat(KIND_PUSH, 8'($urandom_range(3)), $urandom);
      join
      send_beat(KIND_READ, 8'd2, 0);
      drain();

      send_idle_pct = 38; recv_idle_pct = 59;
      random_phase(100, 15);
      drain();
      write_key_count(9'd8);
      send_idle_pct = 59; recv_idle_pct = 38;
      random_phase(100, 11);
      drain();
      write_key_count(9'd256);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_phase(100, 255);
      drain();

      if (errors == 0 && expected_beats.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
